[sv/cdm_pkg.sv]
package cdm_pkg;

  localparam int unsigned CHAN_W = 8;
  localparam int unsigned NUM_INKS = 3;
  localparam int unsigned PROD_W = 2 * CHAN_W;
  localparam int unsigned STEP_BITS = 4;
  localparam logic [CHAN_W-1:0] THRESHOLD_RESET = 8'd25;

  typedef logic [CHAN_W-1:0] chan_t;

  typedef struct packed {
    chan_t blue;
    chan_t green;
    chan_t red;
  } pix_t;

  // Ink levels: [0] cyan (from red), [1] magenta (from green), [2] yellow (from blue)
  typedef logic [NUM_INKS-1:0][CHAN_W-1:0] ink3_t;

  // Stage advance strobes for the ink pipeline
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } cdm_adv_t;

  typedef struct packed {
    chan_t                rem;
    logic [STEP_BITS-1:0] q;
  } div_t;

  // Four restoring division steps. rem < d on entry, so each trial fits CHAN_W+1 bits.
  // A zero divisor only appears with a zero dividend; keep the quotient at zero then.
  function automatic div_t div_steps(input chan_t rem, input logic [STEP_BITS-1:0] bits,
                                     input chan_t d);
    div_t                res;
    logic [CHAN_W:0]     trial;
    chan_t               r;
    begin
      r = rem;
      res.q = '0;
      for (int i = STEP_BITS - 1; i >= 0; i--) begin
        trial = {r, bits[i]};
        if ((d != '0) && (trial >= {1'b0, d})) begin
          trial = trial - {1'b0, d};
          res.q[i] = 1'b1;
        end
        r = trial[CHAN_W-1:0];
      end
      res.rem = r;
      return res;
    end
  endfunction

endpackage

[sv/cdm_ink.sv]
module cdm_ink import cdm_pkg::*; (
  input  logic     clk,
  input  cdm_adv_t adv,
  input  pix_t     pix,
  output ink3_t    ink
);

  // Stage 1: peak channel and scaled numerator (mx - ch) * 255
  chan_t                              mx1;
  logic [NUM_INKS-1:0][PROD_W-1:0]    num1;
  // Stage 2: upper quotient nibble, partial remainder
  chan_t                              mx2;
  logic [NUM_INKS-1:0][CHAN_W-1:0]    rem2;
  logic [NUM_INKS-1:0][STEP_BITS-1:0] qhi2;
  logic [NUM_INKS-1:0][STEP_BITS-1:0] nlo2;
  // Stage 3: finished inks
  ink3_t                              ink3;

  chan_t                              mx_next;
  logic [NUM_INKS-1:0][CHAN_W-1:0]    chans;
  logic [NUM_INKS-1:0][PROD_W-1:0]    num_next;
  logic [NUM_INKS-1:0][CHAN_W-1:0]    diffs;
  div_t [NUM_INKS-1:0]                hi_res;
  div_t [NUM_INKS-1:0]                lo_res;

  always_comb begin
    chans[0] = pix.red;
    chans[1] = pix.green;
    chans[2] = pix.blue;
    mx_next = pix.red;
    if (pix.green > mx_next) begin
      mx_next = pix.green;
    end
    if (pix.blue > mx_next) begin
      mx_next = pix.blue;
    end
    for (int i = 0; i < NUM_INKS; i++) begin
      diffs[i] = mx_next - chans[i];
      // x * 255 as (x << 8) - x
      num_next[i] = {diffs[i], {CHAN_W{1'b0}}} - {{CHAN_W{1'b0}}, diffs[i]};
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_INKS; i++) begin
      hi_res[i] = div_steps(num1[i][PROD_W-1:CHAN_W], num1[i][CHAN_W-1:STEP_BITS], mx1);
      lo_res[i] = div_steps(rem2[i], nlo2[i], mx2);
    end
  end

  always_ff @(posedge clk) begin
    if (adv.s1) begin
      mx1  <= mx_next;
      num1 <= num_next;
    end
    if (adv.s2) begin
      mx2 <= mx1;
      for (int i = 0; i < NUM_INKS; i++) begin
        rem2[i] <= hi_res[i].rem;
        qhi2[i] <= hi_res[i].q;
        nlo2[i] <= num1[i][STEP_BITS-1:0];
      end
    end
    if (adv.s3) begin
      for (int i = 0; i < NUM_INKS; i++) begin
        ink3[i] <= {qhi2[i], lo_res[i].q};
      end
    end
  end

  assign ink = ink3;

endmodule

[sv/cdm_mark.sv]
module cdm_mark import cdm_pkg::*; (
  input  logic  clk,
  input  logic  adv,
  input  ink3_t ink_target,
  input  ink3_t ink_detect,
  input  pix_t  target,
  input  chan_t threshold,
  output chan_t out_blue,
  output chan_t out_green,
  output chan_t out_red,
  output chan_t max_difference,
  output logic  marked
);

  logic [NUM_INKS-1:0][CHAN_W-1:0] ad;
  chan_t                           best;
  logic                            hit;

  always_comb begin
    for (int i = 0; i < NUM_INKS; i++) begin
      ad[i] = (ink_target[i] > ink_detect[i]) ? (ink_target[i] - ink_detect[i])
                                              : (ink_detect[i] - ink_target[i]);
    end
    best = ad[0];
    if (ad[1] > best) begin
      best = ad[1];
    end
    if (ad[2] > best) begin
      best = ad[2];
    end
    hit = best > threshold;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_blue       <= hit ? '0 : target.blue;
      out_green      <= hit ? '0 : target.green;
      out_red        <= hit ? best : target.red;
      max_difference <= best;
      marked         <= hit;
    end
  end

endmodule

[sv/cmyk_difference_map.sv]
// Channel  | Handshake              | Payload
// ---------+------------------------+------------------------------------------------
// input    | in_valid / in_ready    | target_blue/green/red, detect_blue/green/red
// result   | out_valid / out_ready  | out_blue/green/red, max_difference, marked
// config   | cfg_valid / cfg_ready  | mark_threshold
//
// One request per cycle, unless stalled, goes through peak/numerator, upper nibble,
// ink and output registers; the ink division is eight restoring steps in two stages.
// Synchronous active-high reset empties the pipeline and loads the threshold with 25.
// Each stage holds when its successor is full and stalled, so a stall on out_ready
// backs up stage by stage; bubbles squeeze out and nothing is dropped or repeated.
module cmyk_difference_map import cdm_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  chan_t target_blue,
  input  chan_t target_green,
  input  chan_t target_red,
  input  chan_t detect_blue,
  input  chan_t detect_green,
  input  chan_t detect_red,
  output logic  out_valid,
  input  logic  out_ready,
  output chan_t out_blue,
  output chan_t out_green,
  output chan_t out_red,
  output chan_t max_difference,
  output logic  marked,
  input  logic  cfg_valid,
  output logic  cfg_ready,
  input  chan_t mark_threshold
);

  // Threshold register; always writable; change it only while idle, a rule left to the user
  chan_t    threshold;

  // Stage valid bits: peak/numerator, upper nibble, inks, output register
  logic     v1;
  logic     v2;
  logic     v3;
  logic     v4;

  // Target pixel rides alongside the ink pipeline
  pix_t     tpix1;
  pix_t     tpix2;
  pix_t     tpix3;

  cdm_adv_t adv;
  logic     adv4;
  pix_t     tpix_in;
  pix_t     dpix_in;
  ink3_t    ink_t;
  ink3_t    ink_d;

  assign tpix_in = '{blue: target_blue, green: target_green, red: target_red};
  assign dpix_in = '{blue: detect_blue, green: detect_green, red: detect_red};

  // Advance a stage when it is empty or its contents move on
  assign adv4   = !v4 || out_ready;
  assign adv.s3 = !v3 || adv4;
  assign adv.s2 = !v2 || adv.s3;
  assign adv.s1 = !v1 || adv.s2;

  assign in_ready  = adv.s1;
  assign out_valid = v4;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THRESHOLD_RESET;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (cfg_valid) begin
        threshold <= mark_threshold;
      end
      if (adv.s1) begin
        v1 <= in_valid;
      end
      if (adv.s2) begin
        v2 <= v1;
      end
      if (adv.s3) begin
        v3 <= v2;
      end
      if (adv4) begin
        v4 <= v3;
      end
    end
  end

  // Hold the target pixel in step with the ink stages
  always_ff @(posedge clk) begin
    if (adv.s1) begin
      tpix1 <= tpix_in;
    end
    if (adv.s2) begin
      tpix2 <= tpix1;
    end
    if (adv.s3) begin
      tpix3 <= tpix2;
    end
  end

  cdm_ink u_ink_target (
    .clk (clk),
    .adv (adv),
    .pix (tpix_in),
    .ink (ink_t)
  );

  cdm_ink u_ink_detect (
    .clk (clk),
    .adv (adv),
    .pix (dpix_in),
    .ink (ink_d)
  );

  // Final stage: ink differences, their peak, threshold test and output select
  cdm_mark u_mark (
    .clk            (clk),
    .adv            (adv4),
    .ink_target     (ink_t),
    .ink_detect     (ink_d),
    .target         (tpix3),
    .threshold      (threshold),
    .out_blue       (out_blue),
    .out_green      (out_green),
    .out_red        (out_red),
    .max_difference (max_difference),
    .marked         (marked)
  );

endmodule

[test/tb.sv]
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import cdm_pkg::*;

  // One request: the target pixel and the detected pixel, each in BGR order.
  typedef struct packed {
    pix_t target;
    pix_t detect;
  } pair_t;

  // One map pixel as the block returns it.
  typedef struct packed {
    pix_t  px;
    chan_t diff;
    logic  mark;
  } map_t;

  // Predicts the difference map and holds the map pixels still owed by the block.
  class ink_mark_board;
    chan_t       threshold;
    map_t        due_maps[$];
    int unsigned errors;

    function new();
      threshold = THRESHOLD_RESET;
      errors = 0;
    endfunction

    // Ink level of one channel: floor((peak - level) * 255 / peak), zero for black.
    function chan_t ink_level(chan_t peak, chan_t level);
      int unsigned span;
      if (peak == '0) begin
        return '0;
      end
      span = (int'(peak) - int'(level)) * 255;
      return chan_t'(span / int'(peak));
    endfunction

    // Cyan from red, magenta from green, yellow from blue.
    function ink3_t inks_of(pix_t p);
      chan_t peak;
      ink3_t inks;
      peak = p.red;
      if (p.green > peak) begin
        peak = p.green;
      end
      if (p.blue > peak) begin
        peak = p.blue;
      end
      inks[0] = ink_level(peak, p.red);
      inks[1] = ink_level(peak, p.green);
      inks[2] = ink_level(peak, p.blue);
      return inks;
    endfunction

    function map_t map_pixel(pair_t pr);
      ink3_t ti;
      ink3_t di;
      chan_t gap;
      map_t  m;
      ti = inks_of(pr.target);
      di = inks_of(pr.detect);
      m.diff = '0;
      for (int i = 0; i < NUM_INKS; i++) begin
        gap = (ti[i] > di[i]) ? ti[i] - di[i] : di[i] - ti[i];
        if (gap > m.diff) begin
          m.diff = gap;
        end
      end
      m.mark = (m.diff > threshold);
      if (m.mark) begin
        m.px.blue = '0;
        m.px.green = '0;
        m.px.red = m.diff;
      end else begin
        m.px = pr.target;
      end
      return m;
    endfunction

    function void note(pair_t pr);
      due_maps.push_back(map_pixel(pr));
    endfunction

    function void compare_field(string field, logic [CHAN_W-1:0] want,
                                logic [CHAN_W-1:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
      end
    endfunction

    function void check(map_t got);
      map_t want;
      if (due_maps.size() == 0) begin
        errors++;
        $display("%0t: map pixel with no request outstanding, expected none, got %h",
                 $time, got);
        return;
      end
      want = due_maps.pop_front();
      compare_field("out_blue", want.px.blue, got.px.blue);
      compare_field("out_green", want.px.green, got.px.green);
      compare_field("out_red", want.px.red, got.px.red);
      compare_field("max_difference", want.diff, got.diff);
      compare_field("marked", CHAN_W'(want.mark), CHAN_W'(got.mark));
    endfunction

    function int unsigned pending();
      return due_maps.size();
    endfunction
  endclass

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  in_valid = 1'b0;
  logic  out_ready = 1'b0;
  logic  cfg_valid = 1'b0;
  chan_t target_blue = '0;
  chan_t target_green = '0;
  chan_t target_red = '0;
  chan_t detect_blue = '0;
  chan_t detect_green = '0;
  chan_t detect_red = '0;
  chan_t mark_threshold = '0;
  logic  in_ready;
  logic  out_valid;
  logic  cfg_ready;
  chan_t out_blue;
  chan_t out_green;
  chan_t out_red;
  chan_t max_difference;
  logic  marked;

  // quiet: no idling on either side; hold_req: ask the receiver for a long stall.
  logic quiet = 1'b0;
  logic hold_req = 1'b0;

  ink_mark_board board = new();

  cmyk_difference_map dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .target_blue(target_blue),
    .target_green(target_green),
    .target_red(target_red),
    .detect_blue(detect_blue),
    .detect_green(detect_green),
    .detect_red(detect_red),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_blue(out_blue),
    .out_green(out_green),
    .out_red(out_red),
    .max_difference(max_difference),
    .marked(marked),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .mark_threshold(mark_threshold)
  );

  always #5 clk = ~clk;

  // Sample every handshake at the edge that completes it. Everything the testbench
  // drives changes by nonblocking assignment, so the values seen here are the ones
  // the block saw at this edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        board.threshold = mark_threshold;
      end
      if (in_valid && in_ready) begin
        board.note(pair_t'({target_blue, target_green, target_red,
                            detect_blue, detect_green, detect_red}));
      end
      if (out_valid && out_ready) begin
        board.check(map_t'({out_blue, out_green, out_red, max_difference, marked}));
      end
    end
  end

  // Receiver: drop ready now and then; on request, hold it low for a long stretch so
  // the pipeline fills and pushes back on the sender.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (48) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        out_ready <= quiet || ($urandom_range(99) >= 11);
      end
    end
  end

  function automatic pix_t px(int b, int g, int r);
    return {chan_t'(b), chan_t'(g), chan_t'(r)};
  endfunction

  // Move a channel a few steps, clamped to the channel range.
  function automatic chan_t nudge(chan_t c);
    int v;
    v = int'(c) + int'($urandom_range(12)) - 6;
    if (v < 0) begin
      v = 0;
    end
    if (v > 255) begin
      v = 255;
    end
    return chan_t'(v);
  endfunction

  // Mix of request shapes: fully random pairs give large differences; nudged pairs
  // land near the threshold; clipped channels hit the ink extremes; gray and black
  // pixels carry no ink; halved pixels probe rounding of the ink quotient.
  function automatic pair_t pick_pair();
    pair_t                  pr;
    logic [2*3*CHAN_W-1:0]  bits;
    int unsigned            kind;
    chan_t                  level;
    pr.target = 24'($urandom);
    pr.detect = 24'($urandom);
    kind = $urandom_range(99);
    if (kind < 35) begin
      return pr;
    end else if (kind < 70) begin
      pr.detect.blue = nudge(pr.target.blue);
      pr.detect.green = nudge(pr.target.green);
      pr.detect.red = nudge(pr.target.red);
    end else if (kind < 80) begin
      bits = pr;
      for (int c = 0; c < 6; c++) begin
        case ($urandom_range(2))
          0: bits[c*CHAN_W +: CHAN_W] = '0;
          1: bits[c*CHAN_W +: CHAN_W] = '1;
          default: ;
        endcase
      end
      pr = pair_t'(bits);
    end else if (kind < 90) begin
      level = (kind < 83) ? '0 : chan_t'($urandom_range(255));
      pr.target = {level, level, level};
      level = chan_t'($urandom_range(255));
      pr.detect = {level, level, level};
    end else begin
      pr.detect = {pr.target.blue >> 1, pr.target.green >> 1, pr.target.red >> 1};
    end
    return pr;
  endfunction

  // Offer one request, maybe after a one-cycle gap, and hold it until accepted.
  task automatic send_pair(pair_t pr);
    if (!quiet && $urandom_range(99) < 11) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    {target_blue, target_green, target_red} <= pr.target;
    {detect_blue, detect_green, detect_red} <= pr.detect;
    do @(posedge clk); while (!in_ready);
  endtask

  // Stop offering and wait until every outstanding map pixel has come back.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (board.pending() != 0);
  endtask

  // Write the threshold only with the pipeline empty.
  task automatic write_threshold(chan_t level);
    drain();
    cfg_valid <= 1'b1;
    mark_threshold <= level;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    chan_t level;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Corners at the reset threshold: black pixels, white, pure primaries, ties for
    // the brightest channel, exact ink quotients, and a difference right at and just
    // past the threshold.
    send_pair({px(0, 0, 0), px(0, 0, 0)});
    send_pair({px(0, 0, 0), px(255, 255, 255)});
    send_pair({px(0, 0, 0), px(0, 0, 255)});
    send_pair({px(255, 0, 0), px(0, 255, 0)});
    send_pair({px(0, 0, 255), px(1, 0, 0)});
    send_pair({px(255, 230, 255), px(255, 255, 255)});
    send_pair({px(255, 229, 255), px(255, 255, 255)});
    send_pair({px(0, 1, 3), px(0, 2, 3)});
    send_pair({px(255, 255, 255), px(1, 1, 1)});
    send_pair({px(128, 64, 32), px(64, 32, 16)});
    send_pair({px(200, 200, 10), px(10, 200, 200)});
    send_pair({px(254, 0, 1), px(1, 254, 0)});
    send_pair({px(255, 255, 255), px(0, 0, 254)});
    send_pair({px(0, 255, 0), px(0, 0, 0)});
    send_pair({px(85, 170, 255), px(170, 85, 255)});
    send_pair({px(1, 2, 1), px(2, 1, 2)});
    send_pair({px(127, 128, 129), px(129, 128, 127)});
    send_pair({px(255, 0, 255), px(0, 255, 255)});

    // Random phases, each at its own threshold: both extremes, the middle, random
    // values, neighbors of the extremes, and back to the reset value.
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: level = 8'd0;
        1: level = 8'd255;
        2: level = 8'd128;
        4: level = 8'd1;
        5: level = 8'd254;
        7: level = THRESHOLD_RESET;
        default: level = chan_t'($urandom_range(255));
      endcase
      write_threshold(level);
      // Run the phase at the middle threshold with no idling on either side.
      quiet = (p == 2);
      for (int n = 0; n < 180; n++) begin
        // Stall the receiver while requests keep coming.
        if (p == 0 && n == 60) begin
          hold_req = 1'b1;
        end
        send_pair(pick_pair());
      end
    end

    drain();
    repeat (12) @(posedge clk);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("tb: done, errors");
    $finish;
  end

endmodule
